// ===== rtl/rvic_pkg.sv =====
// ----------------------------------------------------------------------------
// rvic_pkg
// types and constants shared by the rv32i instruction core and its checker
// ----------------------------------------------------------------------------
package rvic_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_HALT       = 3'd1,
    ST_ILLEGAL    = 3'd2,
    ST_COMPRESSED = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_STOPPED    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MRD,
    S_DEC,
    S_EXE,
    S_LDW,
    S_RESP
  } state_e;

  localparam logic REG_MEM_BASE = 1'b0;

  localparam logic [31:0] MEM_BASE_RST = 32'h8000_0000;
  localparam logic [31:0] START_PC_RST = 32'h8000_0000;
  localparam logic [31:0] HALT_WORD    = 32'h0000_006f;

  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6f;

  // little-endian word from four byte lanes, lowest byte at lane sh
  function automatic logic [31:0] gather(input logic [31:0] lanes, input logic [1:0] sh);
    logic [31:0] w;
    logic [1:0]  l;
    w = '0;
    for (int i = 0; i < 4; i++) begin
      l = sh + 2'(i);
      w[8*i +: 8] = lanes[8*l +: 8];
    end
    return w;
  endfunction

endpackage

// ===== rtl/rvic_ram.sv =====
// ----------------------------------------------------------------------------
// rvic_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rvic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/rv32i_instruction_core.sv =====
// states: read idle, mrd, resp; running step idle, dec, exe, ldw (loads), resp; else idle, resp
// one request at a time; next request taken once the result sits in the output register
// the byte memory is four byte-lane rams, each step reads it for fetch and data
// reset clears pc to 0x80000000, mem_base to 0x80000000, registers to zero
// byte memory is not cleared; MEM_BYTES must be a power of two
// ----------------------------------------------------------------------------
// rv32i_instruction_core
// rv32i core with private byte memory, driven by write, read and step requests
// ----------------------------------------------------------------------------
module rv32i_instruction_core #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] addr_i,
  input  logic [31:0] wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] next_pc_o,
  output logic [31:0] read_data_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int RW   = AW - 2;
  localparam int ROWS = MEM_BYTES / 4;

  rvic_pkg::state_e  state_q, state_d;
  rvic_pkg::status_e run_q, res_status_q;
  logic [31:0] mem_base_q, pc_q, inst_q;
  logic [31:0] res_rdata_q, res_val_q;
  logic        res_wr_q;
  logic [4:0]  res_idx_q;
  logic [1:0]  acc_sh_q;
  logic [2:0]  ld_f3_q;
  logic [4:0]  ld_rd_q;
  logic [31:0] rf_valid_q;
  logic        rs1_ok_q, rs2_ok_q;

  logic        in_acc;
  logic [31:0] mem_addr, mem_off, lane_rd, lane_wd;
  logic [3:0]  lane_we;
  logic [RW-1:0] lane_row [4];
  logic [RW-1:0] row_base;
  logic [1:0]  sh;
  logic [31:0] inst_w, rd_word;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata, rf_a_raw, rf_b_raw, a, b;

  // execute signals
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, ea, tgt;
  rvic_pkg::status_e exe_status;
  logic [31:0] exe_npc, exe_val, ld_val;
  logic        exe_wr, exe_load, exe_store, take;
  logic [4:0]  shamt;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;

  // byte lane rams
  assign mem_off  = mem_addr & ~mem_base_q;
  assign sh       = mem_off[1:0];
  assign row_base = mem_off[AW-1:2];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign lane_row[l] = row_base + RW'(2'(l) < sh);
    rvic_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
      .clk_i  (clk_i),
      .we_i   (lane_we[l]),
      .waddr_i(lane_row[l]),
      .wdata_i(lane_wd[8*l +: 8]),
      .raddr_i(lane_row[l]),
      .rdata_o(lane_rd[8*l +: 8])
    );
  end

  assign inst_w  = rvic_pkg::gather(lane_rd, acc_sh_q);
  assign rd_word = rvic_pkg::gather(lane_rd, acc_sh_q);

  // register file, one copy per read port
  rvic_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk_i(clk_i), .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(inst_w[19:15]), .rdata_o(rf_a_raw)
  );
  rvic_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk_i(clk_i), .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(inst_w[24:20]), .rdata_o(rf_b_raw)
  );

  assign a = rs1_ok_q ? rf_a_raw : '0;
  assign b = rs2_ok_q ? rf_b_raw : '0;

  // decode and execute
  assign op    = inst_q[6:0];
  assign rd    = inst_q[11:7];
  assign f3    = inst_q[14:12];
  assign imm_i = {{20{inst_q[31]}}, inst_q[31:20]};
  assign imm_s = {{20{inst_q[31]}}, inst_q[31:25], inst_q[11:7]};
  assign imm_b = {{19{inst_q[31]}}, inst_q[31], inst_q[7], inst_q[30:25], inst_q[11:8], 1'b0};
  assign imm_j = {{11{inst_q[31]}}, inst_q[31], inst_q[19:12], inst_q[20], inst_q[30:21], 1'b0};
  assign ea    = a + ((op == rvic_pkg::OP_STORE) ? imm_s : imm_i);
  assign tgt   = pc_q + ((op == rvic_pkg::OP_JAL) ? imm_j : imm_b);
  assign shamt = (op == rvic_pkg::OP_REG) ? b[4:0] : imm_i[4:0];

  always_comb begin
    logic [31:0] opb;
    logic        alt;
    opb        = (op == rvic_pkg::OP_REG) ? b : imm_i;
    alt        = (op == rvic_pkg::OP_REG) ? inst_q[30] : imm_i[10];
    exe_status = rvic_pkg::ST_OK;
    exe_npc    = pc_q + 32'd4;
    exe_val    = '0;
    exe_wr     = 1'b0;
    exe_load   = 1'b0;
    exe_store  = 1'b0;
    take       = 1'b0;
    if (inst_q[1:0] != 2'b11) begin
      exe_status = rvic_pkg::ST_COMPRESSED;
    end else if (inst_q == rvic_pkg::HALT_WORD) begin
      exe_status = rvic_pkg::ST_HALT;
    end else begin
      unique case (op)
        rvic_pkg::OP_LOAD: begin
          if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
            exe_status = rvic_pkg::ST_ILLEGAL;
          end else begin
            exe_load = 1'b1;
          end
        end
        rvic_pkg::OP_IMM, rvic_pkg::OP_REG: begin
          exe_wr = 1'b1;
          unique case (f3)
            3'd0: exe_val = (op == rvic_pkg::OP_REG && alt) ? a - opb : a + opb;
            3'd1: exe_val = a << shamt;
            3'd2: exe_val = {31'd0, $signed(a) < $signed(opb)};
            3'd3: exe_val = {31'd0, a < opb};
            3'd4: exe_val = a ^ opb;
            3'd5: exe_val = alt ? 32'($signed(a) >>> shamt) : a >> shamt;
            3'd6: exe_val = a | opb;
            default: exe_val = a & opb;
          endcase
        end
        rvic_pkg::OP_STORE: begin
          if (f3 > 3'd2) begin
            exe_status = rvic_pkg::ST_ILLEGAL;
          end else begin
            exe_store = 1'b1;
          end
        end
        rvic_pkg::OP_LUI: begin
          exe_wr  = 1'b1;
          exe_val = {inst_q[31:12], 12'd0};
        end
        rvic_pkg::OP_AUIPC: begin
          exe_wr  = 1'b1;
          exe_val = {inst_q[31:12], 12'd0} + pc_q;
        end
        rvic_pkg::OP_BRANCH: begin
          unique case (f3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: exe_status = rvic_pkg::ST_ILLEGAL;
          endcase
          if (take) begin
            exe_npc = tgt;
            if (tgt[1]) begin
              exe_status = rvic_pkg::ST_MISALIGNED;
            end
          end
        end
        rvic_pkg::OP_JAL: begin
          exe_npc = tgt;
          exe_wr  = 1'b1;
          exe_val = pc_q + 32'd4;
          if (tgt[1]) begin
            exe_status = rvic_pkg::ST_MISALIGNED;
          end
        end
        rvic_pkg::OP_JALR: begin
          exe_npc = {ea[31:1], 1'b0};
          exe_wr  = 1'b1;
          exe_val = pc_q + 32'd4;
          if (f3 != 3'd0) begin
            exe_status = rvic_pkg::ST_ILLEGAL;
          end else if (ea[1]) begin
            exe_status = rvic_pkg::ST_MISALIGNED;
          end
        end
        default: exe_status = rvic_pkg::ST_ILLEGAL;
      endcase
    end
  end

  // load extension
  always_comb begin
    unique case (ld_f3_q)
      3'd0:    ld_val = {{24{rd_word[7]}}, rd_word[7:0]};
      3'd1:    ld_val = {{16{rd_word[15]}}, rd_word[15:0]};
      3'd4:    ld_val = {24'd0, rd_word[7:0]};
      3'd5:    ld_val = {16'd0, rd_word[15:0]};
      default: ld_val = rd_word;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rvic_pkg::S_IDLE: begin
        if (in_acc) begin
          if (cmd_i == rvic_pkg::CMD_READ) begin
            state_d = rvic_pkg::S_MRD;
          end else if (cmd_i == rvic_pkg::CMD_STEP && run_q == rvic_pkg::ST_OK) begin
            state_d = rvic_pkg::S_DEC;
          end else begin
            state_d = rvic_pkg::S_RESP;
          end
        end
      end
      rvic_pkg::S_MRD: state_d = rvic_pkg::S_RESP;
      rvic_pkg::S_DEC: state_d = rvic_pkg::S_EXE;
      rvic_pkg::S_EXE: begin
        state_d = (exe_status == rvic_pkg::ST_OK && exe_load) ? rvic_pkg::S_LDW
                                                              : rvic_pkg::S_RESP;
      end
      rvic_pkg::S_LDW: state_d = rvic_pkg::S_RESP;
      rvic_pkg::S_RESP: begin
        if (!out_valid_o || out_ready_i) begin
          state_d = rvic_pkg::S_IDLE;
        end
      end
      default: state_d = rvic_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    logic [1:0] i2;
    in_ready_o = 1'b0;
    mem_addr   = addr_i;
    lane_we    = '0;
    lane_wd    = wdata_i;
    rf_we      = 1'b0;
    rf_waddr   = rd;
    rf_wdata   = exe_val;
    unique case (state_q)
      rvic_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (cmd_i == rvic_pkg::CMD_STEP) begin
          mem_addr = pc_q;
        end
        if (in_acc && cmd_i == rvic_pkg::CMD_WRITE) begin
          lane_we = 4'hf;
        end
        for (int l = 0; l < 4; l++) begin
          i2 = 2'(l) - sh;
          lane_wd[8*l +: 8] = wdata_i[8*i2 +: 8];
        end
      end
      rvic_pkg::S_EXE: begin
        mem_addr = ea;
        for (int l = 0; l < 4; l++) begin
          i2 = 2'(l) - sh;
          lane_wd[8*l +: 8] = b[8*i2 +: 8];
          lane_we[l] = exe_status == rvic_pkg::ST_OK && exe_store &&
                       (i2 == 2'd0 || (i2 == 2'd1 && f3 != 3'd0) || f3 == 3'd2);
        end
        rf_we = exe_status == rvic_pkg::ST_OK && exe_wr && rd != 5'd0;
      end
      rvic_pkg::S_LDW: begin
        rf_we    = ld_rd_q != 5'd0;
        rf_waddr = ld_rd_q;
        rf_wdata = ld_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rvic_pkg::S_IDLE;
      run_q       <= rvic_pkg::ST_OK;
      mem_base_q  <= rvic_pkg::MEM_BASE_RST;
      pc_q        <= rvic_pkg::START_PC_RST;
      rf_valid_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_index_i == rvic_pkg::REG_MEM_BASE) begin
        mem_base_q <= cfg_data_i;
      end
      if (rf_we) begin
        rf_valid_q[rf_waddr] <= 1'b1;
      end
      if (state_q == rvic_pkg::S_EXE) begin
        if (exe_status == rvic_pkg::ST_OK) begin
          pc_q <= exe_npc;
        end else begin
          run_q <= exe_status;
        end
      end
      if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (state_q == rvic_pkg::S_RESP && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rvic_pkg::S_IDLE: begin
        acc_sh_q     <= sh;
        res_status_q <= (cmd_i == rvic_pkg::CMD_STEP && run_q != rvic_pkg::ST_OK)
                        ? rvic_pkg::ST_STOPPED : rvic_pkg::ST_OK;
        res_rdata_q  <= '0;
        res_wr_q     <= 1'b0;
        res_idx_q    <= '0;
        res_val_q    <= '0;
      end
      rvic_pkg::S_MRD: res_rdata_q <= rd_word;
      rvic_pkg::S_DEC: begin
        inst_q   <= inst_w;
        rs1_ok_q <= rf_valid_q[inst_w[19:15]];
        rs2_ok_q <= rf_valid_q[inst_w[24:20]];
      end
      rvic_pkg::S_EXE: begin
        acc_sh_q     <= sh;
        ld_f3_q      <= f3;
        ld_rd_q      <= rd;
        res_status_q <= exe_status;
        if (rf_we) begin
          res_wr_q  <= 1'b1;
          res_idx_q <= rd;
          res_val_q <= exe_val;
        end
      end
      rvic_pkg::S_LDW: begin
        if (rf_we) begin
          res_wr_q  <= 1'b1;
          res_idx_q <= ld_rd_q;
          res_val_q <= ld_val;
        end
      end
      rvic_pkg::S_RESP: begin
        if (!out_valid_o || out_ready_i) begin
          status_o      <= res_status_q;
          next_pc_o     <= pc_q;
          read_data_o   <= res_rdata_q;
          reg_written_o <= res_wr_q;
          reg_index_o   <= res_idx_q;
          reg_value_o   <= res_val_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/rvic_checker.sv =====
// ----------------------------------------------------------------------------
// rvic_checker
// port-level checks on the result channel of the rv32i instruction core
// ----------------------------------------------------------------------------
module rvic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic        reg_written_o,
  input logic [4:0]  reg_index_o,
  input logic [31:0] reg_value_o,
  input logic [31:0] read_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_no_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_written_o |-> reg_index_o != 5'd0)
    else $error("write reported for x0");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reg_written_o |-> reg_index_o == 5'd0 && reg_value_o == 32'd0)
    else $error("register fields set without a write");

  a_err_no_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rvic_pkg::ST_OK |-> !reg_written_o && read_data_o == 32'd0)
    else $error("failed step reported a write");

endmodule

bind rv32i_instruction_core rvic_checker u_rvic_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .reg_written_o(reg_written_o),
  .reg_index_o  (reg_index_o),
  .reg_value_o  (reg_value_o),
  .read_data_o  (read_data_o)
);

// ===== bench/rv32i_instruction_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rv32i_instruction_core_tb
// runs a short table of requests with typed answers for the obvious rows, then
// random programs written at the pc just before each step, under changing base
// masks and handshake stalls, and ends with one sticky stop. every byte is
// written before it is read. untyped results are checked by an in-bench model
// ----------------------------------------------------------------------------
module rv32i_instruction_core_tb;

  localparam logic REG_START_PC = 1'b1;
  localparam int   WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    rvic_pkg::status_e status;
    logic [31:0]       next_pc;
    logic [31:0]       read_data;
    logic              reg_written;
    logic [4:0]        reg_index;
    logic [31:0]       reg_value;
  } core_result_t;

  typedef struct packed {
    rvic_pkg::cmd_e cmd;
    logic [31:0]    addr;
    logic [31:0]    data;
    logic           typed;
    core_result_t   want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [1:0]  cmd = rvic_pkg::CMD_NONE;
  logic [31:0] addr = '0;
  logic [31:0] wdata = '0;
  logic        out_ready = 1'b0;
  logic        cfg_ready_o, in_ready_o, out_valid_o, reg_written_o;
  logic [2:0]  status_o;
  logic [31:0] next_pc_o, read_data_o, reg_value_o;
  logic [4:0]  reg_index_o;

  rv32i_instruction_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready_o), .cmd_i(cmd), .addr_i(addr),
    .wdata_i(wdata),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready), .status_o(status_o),
    .next_pc_o(next_pc_o), .read_data_o(read_data_o), .reg_written_o(reg_written_o),
    .reg_index_o(reg_index_o), .reg_value_o(reg_value_o)
  );

  // core image
  logic [7:0]        mem_image [65536];
  bit                mem_known [65536];
  logic [31:0]       gpr [32];
  logic [31:0]       pc_model;
  rvic_pkg::status_e run_state;
  logic [31:0]       mem_base_m;
  logic [31:0]       start_pc_m;

  core_result_t pending_results [$];
  int           src_idle = 0;
  int           snk_idle = 0;
  int           fail_count = 0;
  int           quiet_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] byte_off(input logic [31:0] a, input int i);
    return 16'((a & ~mem_base_m) + 32'(i));
  endfunction

  function automatic logic [31:0] mem_word(input logic [31:0] a, input int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = mem_image[byte_off(a, i)];
    return v;
  endfunction

  function automatic logic mem_ready(input logic [31:0] a, input int n);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < n; i++) if (!mem_known[byte_off(a, i)]) ok = 1'b0;
    return ok;
  endfunction

  task automatic mem_store(input logic [31:0] a, input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) begin
      mem_image[byte_off(a, i)] = v[8*i +: 8];
      mem_known[byte_off(a, i)] = 1'b1;
    end
  endtask

  // decode and execute one word against the current image, no state change
  function automatic rvic_pkg::status_e exec_insn(input logic [31:0] w, output logic dowr,
                                        output logic [31:0] res, output logic [31:0] npc,
                                        output int st_n, output logic [31:0] st_addr);
    logic [31:0] a, b, immi, ea, off, m;
    logic [2:0]  f3;
    logic        take;
    a = gpr[w[19:15]];
    b = gpr[w[24:20]];
    immi = {{20{w[31]}}, w[31:20]};
    f3 = w[14:12];
    npc = pc_model + 32'd4;
    res = '0;
    dowr = 1'b0;
    st_n = 0;
    st_addr = '0;
    take = 1'b0;
    if (w[1:0] != 2'b11) return rvic_pkg::ST_COMPRESSED;
    if (w == rvic_pkg::HALT_WORD) return rvic_pkg::ST_HALT;
    case (w[6:0])
      rvic_pkg::OP_LOAD: begin
        ea = a + immi;
        case (f3)
          3'd0: begin m = mem_word(ea, 1); res = {{24{m[7]}}, m[7:0]}; end
          3'd1: begin m = mem_word(ea, 2); res = {{16{m[15]}}, m[15:0]}; end
          3'd2: res = mem_word(ea, 4);
          3'd4: res = mem_word(ea, 1);
          3'd5: res = mem_word(ea, 2);
          default: return rvic_pkg::ST_ILLEGAL;
        endcase
        dowr = 1'b1;
      end
      rvic_pkg::OP_IMM: begin
        case (f3)
          3'd0: res = a + immi;
          3'd1: res = a << immi[4:0];
          3'd2: res = ($signed(a) < $signed(immi)) ? 32'd1 : 32'd0;
          3'd3: res = (a < immi) ? 32'd1 : 32'd0;
          3'd4: res = a ^ immi;
          3'd5: res = immi[10] ? 32'($signed(a) >>> immi[4:0]) : a >> immi[4:0];
          3'd6: res = a | immi;
          default: res = a & immi;
        endcase
        dowr = 1'b1;
      end
      rvic_pkg::OP_REG: begin
        case (f3)
          3'd0: res = w[30] ? a - b : a + b;
          3'd1: res = a << b[4:0];
          3'd2: res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          3'd3: res = (a < b) ? 32'd1 : 32'd0;
          3'd4: res = a ^ b;
          3'd5: res = w[30] ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
          3'd6: res = a | b;
          default: res = a & b;
        endcase
        dowr = 1'b1;
      end
      rvic_pkg::OP_STORE: begin
        if (f3 > 3'd2) return rvic_pkg::ST_ILLEGAL;
        st_addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
        st_n = 1 << f3;
      end
      rvic_pkg::OP_LUI: begin
        res = {w[31:12], 12'b0};
        dowr = 1'b1;
      end
      rvic_pkg::OP_AUIPC: begin
        res = {w[31:12], 12'b0} + pc_model;
        dowr = 1'b1;
      end
      rvic_pkg::OP_BRANCH: begin
        off = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = ($signed(a) < $signed(b));
          3'd5: take = !($signed(a) < $signed(b));
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: return rvic_pkg::ST_ILLEGAL;
        endcase
        if (take) begin
          npc = pc_model + off;
          if (npc[1]) return rvic_pkg::ST_MISALIGNED;
        end
      end
      rvic_pkg::OP_JAL: begin
        off = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        npc = pc_model + off;
        if (npc[1]) return rvic_pkg::ST_MISALIGNED;
        res = pc_model + 32'd4;
        dowr = 1'b1;
      end
      rvic_pkg::OP_JALR: begin
        if (f3 != 3'd0) return rvic_pkg::ST_ILLEGAL;
        npc = (a + immi) & ~32'h1;
        if (npc[1]) return rvic_pkg::ST_MISALIGNED;
        res = pc_model + 32'd4;
        dowr = 1'b1;
      end
      default: return rvic_pkg::ST_ILLEGAL;
    endcase
    return rvic_pkg::ST_OK;
  endfunction

  task automatic apply_request(input rvic_pkg::cmd_e c, input logic [31:0] a,
                               input logic [31:0] d, output core_result_t r);
    logic              dowr;
    logic [31:0]       res, npc, st_addr, w;
    int                st_n;
    rvic_pkg::status_e st;
    r = '0;
    r.status = rvic_pkg::ST_OK;
    case (c)
      rvic_pkg::CMD_WRITE: mem_store(a, d, 4);
      rvic_pkg::CMD_READ:  r.read_data = mem_word(a, 4);
      rvic_pkg::CMD_STEP: begin
        if (run_state != rvic_pkg::ST_OK) begin
          r.status = rvic_pkg::ST_STOPPED;
        end else begin
          w = mem_word(pc_model, 4);
          st = exec_insn(w, dowr, res, npc, st_n, st_addr);
          if (st == rvic_pkg::ST_OK) begin
            if (st_n != 0) mem_store(st_addr, gpr[w[24:20]], st_n);
            if (dowr && w[11:7] != 5'd0) begin
              gpr[w[11:7]] = res;
              r.reg_written = 1'b1;
              r.reg_index = w[11:7];
              r.reg_value = res;
            end
            pc_model = npc;
          end
          run_state = st;
          r.status = st;
        end
      end
      default: ;
    endcase
    r.next_pc = pc_model;
  endtask

  task automatic issue(input rvic_pkg::cmd_e c, input logic [31:0] a, input logic [31:0] d,
                       input logic use_typed, input core_result_t typed_r);
    core_result_t r;
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    addr <= a;
    wdata <= d;
    do @(posedge clk); while (!in_ready_o);
    apply_request(c, a, d, r);
    pending_results.push_back(use_typed ? typed_r : r);
  endtask

  task automatic send(input rvic_pkg::cmd_e c, input logic [31:0] a, input logic [31:0] d);
    issue(c, a, d, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == rvic_pkg::REG_MEM_BASE) mem_base_m = v;
    else start_pc_m = v;
    @(posedge clk);
  endtask

  // legal instruction that completes without a stop, falls back to addi
  function automatic logic [31:0] pick_insn();
    logic [31:0] w, res, npc, st_addr;
    logic        dowr;
    int          st_n;
    logic [2:0]  ld_f3 [5] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd5};
    logic [2:0]  br_f3 [6] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7};
    logic [6:0]  ops [9] = '{rvic_pkg::OP_LOAD, rvic_pkg::OP_IMM, rvic_pkg::OP_AUIPC,
                            rvic_pkg::OP_STORE, rvic_pkg::OP_REG, rvic_pkg::OP_LUI,
                            rvic_pkg::OP_BRANCH, rvic_pkg::OP_JALR, rvic_pkg::OP_JAL};
    for (int t = 0; t < 16; t++) begin
      w = $urandom;
      w[6:0] = ops[$urandom_range(0, 8)];
      case (w[6:0])
        rvic_pkg::OP_LOAD:   w[14:12] = ld_f3[$urandom_range(0, 4)];
        rvic_pkg::OP_STORE:  w[14:12] = 3'($urandom_range(0, 2));
        rvic_pkg::OP_BRANCH: w[14:12] = br_f3[$urandom_range(0, 5)];
        rvic_pkg::OP_JALR:   w[14:12] = 3'd0;
        default: ;
      endcase
      if (exec_insn(w, dowr, res, npc, st_n, st_addr) == rvic_pkg::ST_OK) return w;
    end
    w = $urandom;
    w[6:0] = rvic_pkg::OP_IMM;
    w[14:12] = 3'd0;
    return w;
  endfunction

  // load data is written ahead of the instruction so no unwritten byte is read
  task automatic step_insn(input logic [31:0] w);
    logic [31:0] ea;
    ea = gpr[w[19:15]] + {{20{w[31]}}, w[31:20]};
    if (w[6:0] == rvic_pkg::OP_LOAD && !mem_ready(ea, 4))
      send(rvic_pkg::CMD_WRITE, ea, $urandom);
    send(rvic_pkg::CMD_WRITE, pc_model, w);
    send(rvic_pkg::CMD_STEP, $urandom, $urandom);
  endtask

  task automatic random_phase(input int n_items);
    int          n, k;
    logic [31:0] a;
    n = 0;
    while (n < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        step_insn(pick_insn());
        n += 2;
      end else if (k < 70) begin
        send(rvic_pkg::CMD_WRITE, $urandom, $urandom);
        n++;
      end else if (k < 88) begin
        a = $urandom;
        if (!mem_ready(a, 4)) begin
          send(rvic_pkg::CMD_WRITE, a, $urandom);
          n++;
        end
        send(rvic_pkg::CMD_READ, a, $urandom);
        n++;
      end else if (k < 94) begin
        a = $urandom;
        send(rvic_pkg::CMD_WRITE, a, $urandom);
        send(rvic_pkg::CMD_READ, a, $urandom);
        n += 2;
      end else begin
        send(rvic_pkg::CMD_NONE, $urandom, $urandom);
        n++;
      end
    end
  endtask

  // result check and watchdog
  always @(posedge clk) begin
    core_result_t want;
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10) $display("unexpected result status %0d", status_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || next_pc_o !== want.next_pc ||
            read_data_o !== want.read_data || reg_written_o !== want.reg_written ||
            reg_index_o !== want.reg_index || reg_value_o !== want.reg_value) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("mismatch exp st %0d pc %h rd %h wr %b x%0d=%h got st %0d pc %h rd %h wr %b x%0d=%h",
                     want.status, want.next_pc, want.read_data, want.reg_written,
                     want.reg_index, want.reg_value, status_o, next_pc_o, read_data_o,
                     reg_written_o, reg_index_o, reg_value_o);
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= snk_idle);
  end

  table_row_t directed [19];

  initial begin
    logic [31:0] w;
    directed = '{
      '{rvic_pkg::CMD_NONE,  32'h0, 32'h0, 1'b1,
        '{rvic_pkg::ST_OK, 32'h8000_0000, 32'h0, 1'b0, 5'd0, 32'h0}},
      '{rvic_pkg::CMD_WRITE, 32'h8000_0100, 32'hFFFF_FFFF, 1'b1,
        '{rvic_pkg::ST_OK, 32'h8000_0000, 32'h0, 1'b0, 5'd0, 32'h0}},
      '{rvic_pkg::CMD_READ,  32'h8000_0100, 32'h0, 1'b1,
        '{rvic_pkg::ST_OK, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 5'd0, 32'h0}},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'hFFFF_FFB7, 1'b1,
        '{rvic_pkg::ST_OK, 32'h8000_0004, 32'h0, 1'b1, 5'd31, 32'hFFFF_F000}},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'hFFF0_0093, 1'b1,
        '{rvic_pkg::ST_OK, 32'h8000_0008, 32'h0, 1'b1, 5'd1, 32'hFFFF_FFFF}},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h7FF0_0113, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h7FFF_D193, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h4020_8233, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h0020_A2B3, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h0020_B333, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h401F_D3B3, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h11F0_2023, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h1010_0403, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h1020_5483, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h8000_0517, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h0000_9463, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h0080_00EF, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h0000_85E7, 1'b0, '0},
      '{rvic_pkg::CMD_STEP,  32'h0, 32'h0040_9613, 1'b0, '0}
    };
    mem_base_m = rvic_pkg::MEM_BASE_RST;
    start_pc_m = rvic_pkg::START_PC_RST;
    pc_model = rvic_pkg::START_PC_RST;
    run_state = rvic_pkg::ST_OK;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].cmd == rvic_pkg::CMD_STEP)
        send(rvic_pkg::CMD_WRITE, pc_model, directed[i].data);
      issue(directed[i].cmd, directed[i].addr, directed[i].data, directed[i].typed,
            directed[i].want);
    end
    drain();

    write_reg(rvic_pkg::REG_MEM_BASE, 32'h0);
    write_reg(REG_START_PC, 32'h0);
    src_idle = 16;
    snk_idle = 63;
    random_phase(350);
    drain();

    write_reg(rvic_pkg::REG_MEM_BASE, 32'hFFFF_FFFF);
    write_reg(REG_START_PC, 32'hFFFF_FFFF);
    src_idle = 63;
    snk_idle = 16;
    random_phase(350);
    drain();

    write_reg(rvic_pkg::REG_MEM_BASE, $urandom);
    write_reg(REG_START_PC, $urandom);
    src_idle = 0;
    snk_idle = 0;
    random_phase(350);

    // one sticky stop, then requests while stopped
    case ($urandom_range(0, 3))
      0: w = rvic_pkg::HALT_WORD;
      1: w = 32'h0000_0001;
      2: w = 32'h0000_007F;
      default: w = 32'h0020_006F;
    endcase
    step_insn(w);
    send(rvic_pkg::CMD_STEP, $urandom, $urandom);
    w = $urandom;
    send(rvic_pkg::CMD_WRITE, w, $urandom);
    send(rvic_pkg::CMD_READ, w, $urandom);
    send(rvic_pkg::CMD_NONE, $urandom, $urandom);
    send(rvic_pkg::CMD_STEP, $urandom, $urandom);
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
